[design/speck128_192_ctr_stream_xor_macros.svh]
// Assertion macros shared by the Speck counter-mode stream XOR design.
`ifndef SPECK128_192_CTR_STREAM_XOR_MACROS_SVH
`define SPECK128_192_CTR_STREAM_XOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define SPK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante.
`define SPK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPK_ASSERT_SAME(label, ante, cons, msg)
`define SPK_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/spk_pkg.sv]
// Types, constants and round functions for the Speck128/192 counter-mode block.
package spk_pkg;

    localparam int ROUNDS  = 33;
    localparam int RK_AW   = $clog2(ROUNDS);
    localparam int WORD_W  = 64;
    localparam int PADDR_W = 6;
    localparam int ROT_X   = 8;
    localparam int ROT_Y   = 3;
    localparam int COUNT_W = 5;

    localparam logic [RK_AW-1:0]   LAST_ROUND = RK_AW'(ROUNDS - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(16);
    localparam logic [COUNT_W-1:0] WORD_BYTES = COUNT_W'(8);

    typedef logic [WORD_W-1:0] word_t;

    // Register index codes, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_KEY_A     = 3'd0,
        REG_KEY_B     = 3'd1,
        REG_KEY_C     = 3'd2,
        REG_NONCE_HI  = 3'd3,
        REG_CTR_START = 3'd4
    } spk_reg_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } spk_state_t;

    typedef struct packed {
        word_t key_a;
        word_t key_b;
        word_t key_c;
        word_t nonce_high;
        word_t counter_start;
    } spk_cfg_t;

    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        word_t            data;
    } spk_rk_wr_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } spk_pair_t;

    // One Speck round: rotate, add, key mix, rotate, mix
    function automatic spk_pair_t speck_round(input word_t x, input word_t y, input word_t k);
        spk_pair_t r;
        r.x = (((x >> ROT_X) | (x << (WORD_W - ROT_X))) + y) ^ k;
        r.y = ((y << ROT_Y) | (y >> (WORD_W - ROT_Y))) ^ r.x;
        return r;
    endfunction

    // Byte mask with the lowest n bytes set (n of eight or more gives all ones)
    function automatic word_t byte_mask(input logic [COUNT_W-1:0] n);
        word_t m;
        for (int j = 0; j < 8; j++) begin
            m[8*j +: 8] = (COUNT_W'(j) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[design/spk_rk_ram.sv]
// Round key memory: one write port, one registered read port.
module spk_rk_ram
    import spk_pkg::*;
(
    input  logic             aclk,
    input  spk_rk_wr_t       wr,
    input  logic [RK_AW-1:0] rd_addr,
    output word_t            rd_data
);

    word_t mem [ROUNDS];
    word_t rd_data_reg;

    // Write the schedule word
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read: data appears in the cycle after the address
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/spk_apb_regs.sv]
// APB configuration registers and key-write strobe.
module spk_apb_regs
    import spk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    output spk_cfg_t           cfg,
    output logic               key_kick
);

    spk_cfg_t cfg_reg;
    logic     key_kick_reg;
    logic     wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    // Write registers; flag key writes so expansion starts from the new words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            key_kick_reg <= 1'b0;
        end else begin
            key_kick_reg <= 1'b0;
            if (wr_en) begin
                case (reg_idx)
                    REG_KEY_A: begin
                        cfg_reg.key_a <= pwdata;
                        key_kick_reg  <= 1'b1;
                    end
                    REG_KEY_B: begin
                        cfg_reg.key_b <= pwdata;
                        key_kick_reg  <= 1'b1;
                    end
                    REG_KEY_C: begin
                        cfg_reg.key_c <= pwdata;
                        key_kick_reg  <= 1'b1;
                    end
                    REG_NONCE_HI:  cfg_reg.nonce_high    <= pwdata;
                    REG_CTR_START: cfg_reg.counter_start <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_KEY_A:     prdata = cfg_reg.key_a;
            REG_KEY_B:     prdata = cfg_reg.key_b;
            REG_KEY_C:     prdata = cfg_reg.key_c;
            REG_NONCE_HI:  prdata = cfg_reg.nonce_high;
            REG_CTR_START: prdata = cfg_reg.counter_start;
            default:       prdata = '0;
        endcase
    end

    assign cfg      = cfg_reg;
    assign key_kick = key_kick_reg;

endmodule

[design/spk_key_exp.sv]
// Key schedule expander: one schedule round per cycle into the round key memory.
`include "speck128_192_ctr_stream_xor_macros.svh"
module spk_key_exp
    import spk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       key_kick,
    input  spk_cfg_t   cfg,
    output spk_rk_wr_t rk_wr,
    output logic       busy
);

    logic             busy_reg, busy_next;
    logic [RK_AW-1:0] idx_reg, idx_next;
    word_t            a_reg, a_next;
    word_t            l0_reg, l0_next;
    word_t            l1_reg, l1_next;
    spk_pair_t        step;

    // Round on the schedule word picked by the index parity
    always_comb begin
        step = speck_round(idx_reg[0] ? l1_reg : l0_reg, a_reg, WORD_W'(idx_reg));
    end

    // Restart on a key write, else advance until the last key is stored
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        a_next    = a_reg;
        l0_next   = l0_reg;
        l1_next   = l1_reg;
        if (key_kick) begin
            busy_next = 1'b1;
            idx_next  = '0;
            a_next    = cfg.key_a;
            l0_next   = cfg.key_b;
            l1_next   = cfg.key_c;
        end else if (busy_reg) begin
            if (idx_reg == LAST_ROUND) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
                a_next   = step.y;
                if (idx_reg[0]) begin
                    l1_next = step.x;
                end else begin
                    l0_next = step.x;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        l0_reg <= l0_next;
        l1_reg <= l1_next;
    end

    // Store the current schedule word as round key idx
    assign rk_wr.en   = busy_reg && !key_kick;
    assign rk_wr.addr = idx_reg;
    assign rk_wr.data = a_reg;
    assign busy       = busy_reg || key_kick;

    `SPK_ASSERT_NEXT(a_kick_starts, key_kick, busy_reg && idx_reg == '0, "expansion did not restart")
    `SPK_ASSERT_NEXT(a_last_stops, busy_reg && !key_kick && idx_reg == LAST_ROUND, !busy_reg, "expansion overran the last key")

endmodule

[design/spk_cipher.sv]
// Counter-mode cipher engine: one Speck round per cycle, keystream XOR and byte masking.
`include "speck128_192_ctr_stream_xor_macros.svh"
module spk_cipher
    import spk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  spk_cfg_t           cfg,
    input  logic               keys_busy,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [WORD_W-1:0]  s_data_low,
    input  logic [WORD_W-1:0]  s_data_high,
    input  logic [COUNT_W-1:0] s_byte_count,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_result_low,
    output logic [WORD_W-1:0]  m_result_high,
    output logic [RK_AW-1:0]   rk_addr,
    input  word_t              rk_data
);

    spk_state_t         state_reg, state_next;
    logic [RK_AW-1:0]   rnd_reg;
    word_t              x_reg, y_reg;
    word_t              ctr_reg;
    word_t              dlo_reg, dhi_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               m_valid_reg;
    word_t              res_lo_reg, res_hi_reg;
    logic               accept, out_free, load_out;
    word_t              ctr_base;
    spk_pair_t          rnd_out;
    word_t              mask_lo, mask_hi;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign ctr_base = s_restart ? cfg.counter_start : ctr_reg;
    assign rnd_out  = speck_round(x_reg, y_reg, rk_data);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (rnd_reg == LAST_ROUND) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: ready, key read address, result load
    always_comb begin
        s_ready  = 1'b0;
        rk_addr  = '0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = !keys_busy;
            ST_RUN:  rk_addr = (rnd_reg == LAST_ROUND) ? rnd_reg : rnd_reg + 1'b1;
            ST_FIN:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            ctr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                rnd_reg <= '0;
                ctr_reg <= ctr_base + 1'b1;
            end else if (state_reg == ST_RUN) begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item and the counter block, then run the rounds
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= cfg.nonce_high;
            y_reg   <= ctr_base;
            dlo_reg <= s_data_low;
            dhi_reg <= s_data_high;
            cnt_reg <= (s_byte_count > FULL_COUNT) ? FULL_COUNT : s_byte_count;
        end else if (state_reg == ST_RUN) begin
            x_reg <= rnd_out.x;
            y_reg <= rnd_out.y;
        end
    end

    // Mix keystream into the data and drop bytes past the count
    assign mask_lo = byte_mask(cnt_reg);
    assign mask_hi = (cnt_reg > WORD_BYTES) ? byte_mask(cnt_reg - WORD_BYTES) : '0;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            res_lo_reg <= (dlo_reg ^ y_reg) & mask_lo;
            res_hi_reg <= (dhi_reg ^ x_reg) & mask_hi;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_low  = res_lo_reg;
    assign m_result_high = res_hi_reg;

    `SPK_ASSERT_NEXT(a_accept_runs, accept, state_reg == ST_RUN && rnd_reg == '0, "item did not start at round zero")
    `SPK_ASSERT_NEXT(a_last_round, state_reg == ST_RUN && rnd_reg == LAST_ROUND, state_reg == ST_FIN, "rounds did not finish")
    `SPK_ASSERT_NEXT(a_fin_holds, state_reg == ST_FIN && m_valid_reg && !m_ready, state_reg == ST_FIN, "finished item overwrote a waiting result")

endmodule

[design/speck128_192_ctr_stream_xor.sv]
// Top level of the Speck128/192 counter-mode stream XOR block.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  s_       | s_valid / s_ready  | data_low, data_high, byte_count, restart
//  m_       | m_valid / m_ready  | result_low, result_high
//  APB      | psel, penable      | paddr, pwdata, prdata (64-bit, 8*i map)
//
// An item passes through the accept cycle, 33 rounds at one round per cycle
// (set by the single read port of the round key memory), and a final state
// that loads the result register. The next item can be accepted in the cycle
// after that. A key register write starts the schedule expansion in the cycle
// after it; s_ready stays low until it ends. Reset is synchronous, active low,
// and does not clear the round key memory. A waiting result stalls the engine
// in its final state until m_ready takes it.
module speck128_192_ctr_stream_xor
    import spk_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [WORD_W-1:0]  s_data_low,
    input  logic [WORD_W-1:0]  s_data_high,
    input  logic [COUNT_W-1:0] s_byte_count,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_result_low,
    output logic [WORD_W-1:0]  m_result_high
);

    spk_cfg_t         cfg;
    logic             key_kick;
    spk_rk_wr_t       rk_wr;
    logic             keys_busy;
    logic [RK_AW-1:0] rk_addr;
    word_t            rk_data;

    spk_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .key_kick (key_kick)
    );

    spk_key_exp u_key_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_kick (key_kick),
        .cfg      (cfg),
        .rk_wr    (rk_wr),
        .busy     (keys_busy)
    );

    spk_rk_ram u_rk_ram (
        .aclk    (aclk),
        .wr      (rk_wr),
        .rd_addr (rk_addr),
        .rd_data (rk_data)
    );

    spk_cipher u_cipher (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .keys_busy     (keys_busy),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_low    (s_data_low),
        .s_data_high   (s_data_high),
        .s_byte_count  (s_byte_count),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_low  (m_result_low),
        .m_result_high (m_result_high),
        .rk_addr       (rk_addr),
        .rk_data       (rk_data)
    );

endmodule

[tb/speck128_192_ctr_stream_xor_test.sv]
// Self-checking testbench for the Speck128/192 counter-mode stream XOR block.
`timescale 1ns / 100ps

module speck128_192_ctr_stream_xor_test
    import spk_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PERCENT = 27;
    localparam int HOLD_AFTER   = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASES       = 5;

    // Register slots past the end of the map, which the block must ignore
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Predicts keystream-XOR results and checks them in order
    class keystream_board;
        word_t key_a, key_b, key_c, nonce_hi, ctr_start;
        word_t sched [ROUNDS];
        word_t counter;
        word_t want_low [$];
        word_t want_high [$];
        int    mismatches;
        int    noted;

        function new();
            key_a = '0; key_b = '0; key_c = '0; nonce_hi = '0; ctr_start = '0;
            counter = '0;
            mismatches = 0;
            noted = 0;
            foreach (sched[i]) sched[i] = '0;
        endfunction

        // Rebuild all round keys from the three key words
        function void expand_schedule();
            word_t a;
            word_t l [2];
            int    j;
            a = key_a;
            l[0] = key_b;
            l[1] = key_c;
            for (int i = 0; i < ROUNDS - 1; i++) begin
                j = i % 2;
                sched[i] = a;
                l[j] = ({l[j][7:0], l[j][63:8]} + a) ^ word_t'(i);
                a = {a[60:0], a[63:61]} ^ l[j];
            end
            sched[ROUNDS-1] = a;
        endfunction

        function void write_reg(logic [2:0] idx, word_t value);
            case (idx)
                REG_KEY_A: begin
                    key_a = value;
                    expand_schedule();
                end
                REG_KEY_B: begin
                    key_b = value;
                    expand_schedule();
                end
                REG_KEY_C: begin
                    key_c = value;
                    expand_schedule();
                end
                REG_NONCE_HI:  nonce_hi = value;
                REG_CTR_START: ctr_start = value;
                default: ;
            endcase
        endfunction

        function word_t low_bytes(int n);
            if (n >= 8)
                return '1;
            return ~({WORD_W{1'b1}} << (8 * n));
        endfunction

        // Encrypt the counter block and queue the masked XOR result
        function void take_block(word_t lo, word_t hi, logic [COUNT_W-1:0] cnt, logic rst);
            word_t x, y;
            int    n;
            n = (cnt > 16) ? 16 : int'(cnt);
            if (rst)
                counter = ctr_start;
            x = nonce_hi;
            y = counter;
            for (int i = 0; i < ROUNDS; i++) begin
                x = ({x[7:0], x[63:8]} + y) ^ sched[i];
                y = {y[60:0], y[63:61]} ^ x;
            end
            want_low.push_back((lo ^ y) & low_bytes(n));
            want_high.push_back((n > 8) ? ((hi ^ x) & low_bytes(n - 8)) : '0);
            counter = counter + 1;
            noted++;
        endfunction

        task report(string what, word_t got, word_t want);
            $display("%0t ns: mismatch in %s: got %h, want %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task match_output(word_t lo, word_t hi);
            word_t el, eh;
            if (want_low.size() == 0) begin
                report("unexpected result", lo, '0);
            end else begin
                el = want_low.pop_front();
                eh = want_high.pop_front();
                if (lo !== el)
                    report("result_low", lo, el);
                if (hi !== eh)
                    report("result_high", hi, eh);
            end
        endtask

        function int pending();
            return want_low.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [WORD_W-1:0]  pwdata;
    logic [WORD_W-1:0]  prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [WORD_W-1:0]  s_data_low;
    logic [WORD_W-1:0]  s_data_high;
    logic [COUNT_W-1:0] s_byte_count;
    logic               s_restart;
    logic               m_valid;
    logic               m_ready;
    logic [WORD_W-1:0]  m_result_low;
    logic [WORD_W-1:0]  m_result_high;

    keystream_board sb = new();
    bit  no_gaps;
    bit  hold_done;
    int  hold_left;
    int  items_sent;
    int  cycle_count;

    speck128_192_ctr_stream_xor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_low    (s_data_low),
        .s_data_high   (s_data_high),
        .s_byte_count  (s_byte_count),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_low  (m_result_low),
        .m_result_high (m_result_high)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Note accepted items and check accepted results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.take_block(s_data_low, s_data_high, s_byte_count, s_restart);
        if (aresetn && m_valid && m_ready)
            sb.match_output(m_result_low, m_result_high);
    end

    // Drive the result side: random stalls, one long hold-off once HOLD_AFTER items are accepted
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sb.noted >= HOLD_AFTER) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one item after a random gap; return at the falling edge after acceptance
    task automatic push_item(word_t lo, word_t hi, logic [COUNT_W-1:0] cnt, logic rst);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_low   <= lo;
        s_data_high  <= hi;
        s_byte_count <= cnt;
        s_restart    <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Register write with setup and access phases; after a key write, hold off while the key schedule rebuilds
    task automatic apb_write(logic [2:0] idx, word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 8);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        if (idx == REG_KEY_A || idx == REG_KEY_B || idx == REG_KEY_C) begin
            repeat (2) @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    task automatic load_settings(word_t ka, word_t kb, word_t kc, word_t nh, word_t cs);
        apb_write(REG_KEY_A, ka);
        apb_write(REG_KEY_B, kb);
        apb_write(REG_KEY_C, kc);
        apb_write(REG_NONCE_HI, nh);
        apb_write(REG_CTR_START, cs);
    endtask

    // One message: optional restart, full blocks, then a final block of 1 to 16 bytes
    task automatic send_message(int blocks, bit fresh);
        logic [COUNT_W-1:0] cnt;
        for (int b = 0; b < blocks; b++) begin
            cnt = (b == blocks - 1) ? COUNT_W'($urandom_range(1, 16)) : FULL_COUNT;
            push_item(rand_word(), rand_word(), cnt, fresh && (b == 0));
        end
    endtask

    initial begin
        int picks [5];
        int choice;
        picks = '{1, 7, 8, 9, 15};
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_data_low   = '0;
        s_data_high  = '0;
        s_byte_count = '0;
        s_restart    = 1'b0;
        m_ready      = 1'b0;
        no_gaps      = 1'b0;
        hold_done    = 1'b0;
        hold_left    = 0;
        items_sent   = 0;
        cycle_count  = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: published key, keystream alone, every byte count edge
        load_settings(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                      64'h0123456789abcdef, '0);
        push_item('0, '0, FULL_COUNT, 1'b1);
        push_item('1, '1, FULL_COUNT, 1'b0);
        push_item(rand_word(), rand_word(), '0, 1'b0);
        foreach (picks[i])
            push_item(rand_word(), rand_word(), COUNT_W'(picks[i]), 1'b0);
        push_item(rand_word(), rand_word(), COUNT_W'(17), 1'b0);
        push_item(rand_word(), rand_word(), '1, 1'b1);
        push_item('1, '0, FULL_COUNT, 1'b0);
        push_item('0, '1, COUNT_W'(12), 1'b0);
        drain();

        // Extremes: counter carries on until a restart, then wraps past all ones
        load_settings('1, '1, '1, '1, {{(WORD_W-1){1'b1}}, 1'b0});
        for (logic [3:0] r = REG_SPARE_LO; r <= REG_SPARE_HI; r++)
            apb_write(r[2:0], rand_word());
        push_item(rand_word(), rand_word(), FULL_COUNT, 1'b0);
        push_item(rand_word(), rand_word(), FULL_COUNT, 1'b0);
        push_item('0, '0, FULL_COUNT, 1'b1);
        push_item('0, '0, FULL_COUNT, 1'b0);
        push_item('0, '0, FULL_COUNT, 1'b0);
        drain();

        load_settings('0, '0, '0, '0, '0);
        push_item(rand_word(), rand_word(), FULL_COUNT, 1'b1);
        push_item('1, '1, COUNT_W'(16), 1'b0);
        drain();

        // Random: mostly well-formed messages, some noise; one phase with no gaps
        for (int phase = 0; phase < PHASES; phase++) begin
            load_settings(rand_word(), rand_word(), rand_word(), rand_word(),
                          (phase == 3) ? {{(WORD_W-4){1'b1}}, 4'h0} : rand_word());
            no_gaps = (phase == 2);
            while (items_sent < 30 + (phase + 1) * PHASE_ITEMS) begin
                choice = $urandom_range(0, 99);
                if (choice < 12)
                    push_item(rand_word(), rand_word(), COUNT_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                else
                    send_message($urandom_range(1, 10), choice >= 20);
            end
            no_gaps = 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
